>>> src/snuv_pkg.sv
// snuv_pkg: constants and angle table for the sphere normal to uv mapper
// no dependencies; imported by sphere_normal_to_uv
package snuv_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 16;
	localparam int ANG_TAB_LEN  = 24;
	localparam int GUARD_BITS   = 16;
	localparam int IN_W         = 16;
	localparam int U_W          = 16;
	localparam int V_W          = 17;
	localparam int CORD_W       = 34;
	localparam int ANG_W        = 31;

	localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(1) << 30;
	localparam logic [V_W-1:0]   V_OFFSET     = V_W'(32768);

	// atan(2^-i) / (2 pi) in Q0.32 turns
	localparam logic [31:0] ANG_TAB [ANG_TAB_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	localparam int LATENCY = CORDIC_STEPS + 2;

endpackage

>>> src/sphere_normal_to_uv.sv
// sphere_normal_to_uv: maps a unit normal to spherical texture coordinates
// cordic vectoring pipeline, one rotation per stage; uses snuv_pkg
//
// channel  | handshake        | payload
// ---------+------------------+-------------------------------
// input    | start / busy     | norm_x, norm_y, norm_z (s16)
// result   | done strobe      | tex_u (u16), tex_v (u17)
//
// one transfer per cycle sustained; busy is always low
// done rises once the transfer has passed through these registers after the accepting edge
// (input register, one stage per cordic rotation, round stage, output register)
// reset clears the valid bits only; results in flight are dropped
// no stalls: the receiver takes every result in its strobe cycle
module sphere_normal_to_uv
	import snuv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [IN_W-1:0] norm_x,
	input  logic signed [IN_W-1:0] norm_y,
	input  logic signed [IN_W-1:0] norm_z,
	output logic                   done,
	output logic        [U_W-1:0]  tex_u,
	output logic        [V_W-1:0]  tex_v
);

	localparam int SH   = FRAC_BITS - U_W;
	localparam int RSH  = (SH > 0) ? SH : 0;
	localparam int LSH  = (SH < 0) ? -SH : 0;
	localparam int EXT_W = FRAC_BITS + U_W + 1;
	localparam logic [EXT_W-1:0] U_RND = EXT_W'((64'd1 << RSH) >> 1);
	localparam logic [ANG_W-1:0] A_RND = ANG_W'(1) << (31 - FRAC_BITS);
	localparam logic [FRAC_BITS:0] HALF_TURN = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
	localparam logic [FRAC_BITS:0] FULL_TURN = (FRAC_BITS+1)'(1) << FRAC_BITS;

	typedef struct packed {
		logic xneg;
		logic zneg;
		logic xzero;
		logic zzero;
	} quad_t;

	// cordic pipeline, index 0 is the input register
	logic                     vld_s   [CORDIC_STEPS+1];
	logic signed [CORD_W-1:0] cx_s    [CORDIC_STEPS+1];
	logic signed [CORD_W-1:0] cy_s    [CORDIC_STEPS+1];
	logic signed [CORD_W-1:0] acc_s   [CORDIC_STEPS+1];
	quad_t                    quad_s  [CORDIC_STEPS+1];
	logic        [V_W-1:0]    v_s     [CORDIC_STEPS+1];

	logic                     vld_sr;
	logic [FRAC_BITS-1:0]     af_sr;
	quad_t                    quad_sr;
	logic [V_W-1:0]           v_sr;

	logic [IN_W:0]            ax, az;
	logic [ANG_W-1:0]         a32;
	logic [ANG_W-1:0]         a_rnd;
	logic [FRAC_BITS:0]       u_w;
	logic [EXT_W-1:0]         u_ext;
	logic [U_W-1:0]           u_out;
	quad_t                    quad_in;

	assign busy = 1'b0;

	always_comb begin
		ax = norm_x[IN_W-1] ? (IN_W+1)'(-$signed({norm_x[IN_W-1], norm_x}))
			: (IN_W+1)'({1'b0, norm_x});
		az = norm_z[IN_W-1] ? (IN_W+1)'(-$signed({norm_z[IN_W-1], norm_z}))
			: (IN_W+1)'({1'b0, norm_z});
		quad_in.xneg  = norm_x[IN_W-1];
		quad_in.xzero = (norm_x == '0);
		quad_in.zzero = (norm_z == '0);
		quad_in.zneg  = norm_z[IN_W-1] || (quad_in.xzero && quad_in.zzero);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= CORD_W'(az) <<< GUARD_BITS;
		cy_s[0]   <= CORD_W'(ax) <<< GUARD_BITS;
		acc_s[0]  <= '0;
		quad_s[0] <= quad_in;
		v_s[0]    <= V_OFFSET - V_W'($signed(norm_y));
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		logic signed [CORD_W-1:0] dx, dy;
		logic signed [CORD_W-1:0] ang;
		assign dx  = cy_s[i] >>> i;
		assign dy  = cx_s[i] >>> i;
		assign ang = CORD_W'(ANG_TAB[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!cy_s[i][CORD_W-1]) begin
				cx_s[i+1]  <= cx_s[i] + dx;
				cy_s[i+1]  <= cy_s[i] - dy;
				acc_s[i+1] <= acc_s[i] + ang;
			end else begin
				cx_s[i+1]  <= cx_s[i] - dx;
				cy_s[i+1]  <= cy_s[i] + dy;
				acc_s[i+1] <= acc_s[i] - ang;
			end
			quad_s[i+1] <= quad_s[i];
			v_s[i+1]    <= v_s[i];
		end
	end

	// clamp, special angles, round to FRAC_BITS
	always_comb begin
		if (acc_s[CORDIC_STEPS][CORD_W-1]) begin
			a32 = '0;
		end else if (acc_s[CORDIC_STEPS] > $signed(CORD_W'(QUARTER_TURN))) begin
			a32 = QUARTER_TURN;
		end else begin
			a32 = ANG_W'(acc_s[CORDIC_STEPS]);
		end
		if (quad_s[CORDIC_STEPS].xzero) begin
			a32 = '0;
		end else if (quad_s[CORDIC_STEPS].zzero) begin
			a32 = QUARTER_TURN;
		end
		a_rnd = a32 + A_RND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else begin
			vld_sr <= vld_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		af_sr   <= FRAC_BITS'(a_rnd >> (32 - FRAC_BITS));
		quad_sr <= quad_s[CORDIC_STEPS];
		v_sr    <= v_s[CORDIC_STEPS];
	end

	// quadrant fold and output rounding
	always_comb begin
		case ({quad_sr.xneg, quad_sr.zneg})
			2'b00:   u_w = {1'b0, af_sr};
			2'b10:   u_w = HALF_TURN + {1'b0, af_sr};
			2'b01:   u_w = HALF_TURN - {1'b0, af_sr};
			default: u_w = FULL_TURN - {1'b0, af_sr};
		endcase
		u_ext = EXT_W'(u_w[FRAC_BITS-1:0]);
		if (SH > 0) begin
			u_out = U_W'((u_ext + U_RND) >> RSH);
		end else begin
			u_out = U_W'(u_ext << LSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sr;
		end
	end

	always_ff @(posedge clk) begin
		tex_u <= u_out;
		tex_v <= v_sr;
	end

	// every accepted transfer is followed by a done from the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(LATENCY + 1) done)
		else $error("accepted transfer gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY + 1))
		else $error("result without a matching transfer");

	a_v_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tex_v != '0) && (tex_v <= V_W'(65536)))
		else $error("tex_v out of range");

	a_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && norm_x == '0 |-> ##(LATENCY + 1)
		(tex_u == '0 || tex_u == U_W'(32768)))
		else $error("zero x gave an off-axis tex_u");

endmodule

>>> tb/sv/sphere_normal_to_uv_tb.sv
// sphere_normal_to_uv_tb: self-checking bench for the normal to uv mapper
// directed table then random normals with random gaps, checked against typed rows or a local predictor
// depends on snuv_pkg and sphere_normal_to_uv
module sphere_normal_to_uv_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import snuv_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RAND_ITEMS  = 1750;
	localparam int N_ROWS      = 21;

	typedef struct packed {
		logic [U_W-1:0] u;
		logic [V_W-1:0] v;
	} uv_t;

	typedef struct packed {
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] z;
		logic                   fixed;
		logic [U_W-1:0]         u;
		logic [V_W-1:0]         v;
	} norm_row_t;

	// fixed rows: axis cases and y extremes; the rest go through the predictor
	localparam norm_row_t ROWS [N_ROWS] = '{
		'{16'sd0, 16'sd0, 16'sh7FFF, 1'b1, 16'd0, 17'd32768},
		'{16'sd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'd32768, 17'd1},
		'{16'sh7FFF, 16'sh8000, 16'sd0, 1'b1, 16'd16384, 17'd65536},
		'{16'sh8000, 16'sd0, 16'sd0, 1'b1, 16'd49152, 17'd32768},
		'{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'd32768, 17'd32768},
		'{16'sd0, -16'sd1, 16'sd1, 1'b1, 16'd0, 17'd32769},
		'{16'sd23170, 16'sd0, 16'sd23170, 1'b0, 16'd0, 17'd0},
		'{-16'sd23170, 16'sd100, 16'sd23170, 1'b0, 16'd0, 17'd0},
		'{16'sd23170, -16'sd100, -16'sd23170, 1'b0, 16'd0, 17'd0},
		'{-16'sd23170, 16'sd16384, -16'sd23170, 1'b0, 16'd0, 17'd0},
		'{-16'sd1, 16'sd0, -16'sd32767, 1'b0, 16'd0, 17'd0},
		'{16'sd1, 16'sd0, 16'sd32767, 1'b0, 16'd0, 17'd0},
		'{16'sh7FFF, 16'sd0, 16'sd1, 1'b0, 16'd0, 17'd0},
		'{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'd0, 17'd0},
		'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'd0, 17'd0},
		'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'd0, 17'd0},
		'{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, 16'd0, 17'd0},
		'{16'sd1, 16'sd1, -16'sd1, 1'b0, 16'd0, 17'd0},
		'{-16'sd1, -16'sd1, 16'sd1, 1'b0, 16'd0, 17'd0},
		'{16'sd12345, -16'sd5000, -16'sd30000, 1'b0, 16'd0, 17'd0},
		'{-16'sd30000, 16'sd20000, 16'sd9000, 1'b0, 16'd0, 17'd0}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic signed [IN_W-1:0] norm_x;
	logic signed [IN_W-1:0] norm_y;
	logic signed [IN_W-1:0] norm_z;
	logic                   done;
	logic        [U_W-1:0]  tex_u;
	logic        [V_W-1:0]  tex_v;

	// typed-in expectation travels with the transfer
	logic                   exp_fixed;
	logic        [U_W-1:0]  exp_u;
	logic        [V_W-1:0]  exp_v;

	uv_t uv_pending [$];
	int  mismatch_cnt;
	int  stall_cycles;

	sphere_normal_to_uv i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.norm_x (norm_x),
		.norm_y (norm_y),
		.norm_z (norm_z),
		.done   (done),
		.tex_u  (tex_u),
		.tex_v  (tex_v)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic uv_t uv_of_normal(input logic signed [IN_W-1:0] x,
			input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] z);
		longint sx, sy, sz, ax, az, cx, cy, dx, dy, acc, af, turn, u, uo, v;
		int     sh;
		logic   xneg, zneg;
		uv_t    r;
		sx = longint'(x);
		sy = longint'(y);
		sz = longint'(z);
		ax = (sx < 0) ? -sx : sx;
		az = (sz < 0) ? -sz : sz;
		xneg = (sx < 0);
		zneg = (sz < 0) || (sx == 0 && sz == 0);
		if (sx == 0) begin
			acc = 0;
		end else if (sz == 0) begin
			acc = longint'(1) <<< 30;
		end else begin
			cx = az <<< GUARD_BITS;
			cy = ax <<< GUARD_BITS;
			acc = 0;
			for (int i = 0; i < CORDIC_STEPS && i < ANG_TAB_LEN; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy >= 0) begin
					cx += dx;
					cy -= dy;
					acc += longint'({32'd0, ANG_TAB[i]});
				end else begin
					cx -= dx;
					cy += dy;
					acc -= longint'({32'd0, ANG_TAB[i]});
				end
			end
			if (acc < 0)
				acc = 0;
			if (acc > (longint'(1) <<< 30))
				acc = longint'(1) <<< 30;
		end
		af = (acc + (longint'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
		turn = longint'(1) <<< FRAC_BITS;
		if (!xneg && !zneg)
			u = af;
		else if (xneg && !zneg)
			u = turn / 2 + af;
		else if (!xneg && zneg)
			u = turn / 2 - af;
		else
			u = turn - af;
		u &= turn - 1;
		sh = FRAC_BITS - 16;
		if (sh > 0)
			uo = (u + ((longint'(1) <<< sh) >>> 1)) >>> sh;
		else
			uo = u <<< (-sh);
		v = 32768 - sy;
		if (v > 65536)
			v = 65536;
		if (v < 0)
			v = 0;
		r.u = uo[U_W-1:0];
		r.v = v[V_W-1:0];
		return r;
	endfunction

	function automatic logic signed [IN_W-1:0] rand_component();
		logic signed [IN_W-1:0] c;
		case ($urandom_range(0, 9))
			0: c = 16'sd0;
			1: c = 16'sh8000;
			2: c = 16'sh7FFF;
			3, 4: c = IN_W'($signed($urandom_range(0, 31)) - 16);
			default: c = IN_W'($urandom);
		endcase
		return c;
	endfunction

	task automatic send_normal(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
			input logic signed [IN_W-1:0] z, input logic fixed, input logic [U_W-1:0] eu,
			input logic [V_W-1:0] ev);
		start <= 1'b1;
		norm_x <= x;
		norm_y <= y;
		norm_z <= z;
		exp_fixed <= fixed;
		exp_u <= eu;
		exp_v <= ev;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap(input logic burst);
		int gap;
		if (!burst && $urandom_range(0, 1) == 1) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		uv_t want;
		if (arst_n) begin
			if (done) begin
				if (uv_pending.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result u=%0d v=%0d", tex_u, tex_v);
				end else begin
					want = uv_pending.pop_front();
					if (tex_u !== want.u || tex_v !== want.v) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch u exp %0d got %0d, v exp %0d got %0d",
								want.u, tex_u, want.v, tex_v);
					end
				end
			end
			if (start && !busy)
				uv_pending.push_back(exp_fixed ? uv_t'{exp_u, exp_v}
					: uv_of_normal(norm_x, norm_y, norm_z));
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic burst;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		norm_x = '0;
		norm_y = '0;
		norm_z = '0;
		exp_fixed = 1'b0;
		exp_u = '0;
		exp_v = '0;
		mismatch_cnt = 0;
		stall_cycles = 0;
		burst = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			send_normal(ROWS[i].x, ROWS[i].y, ROWS[i].z, ROWS[i].fixed, ROWS[i].u, ROWS[i].v);
			idle_gap(1'b0);
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			// back-to-back stretches now and then
			if (i % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			send_normal(rand_component(), rand_component(), rand_component(), 1'b0, '0, '0);
			idle_gap(burst);
		end

		start <= 1'b0;
		while (uv_pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_cnt == 0 && uv_pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
